// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, codes and helpers of the LRU key-value cache with lease.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int LEN_W   = 4;
    localparam int TIME_W  = 32;
    localparam int MAX_LEN = 8;

    // response status codes
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // register index codes (byte address 4*i)
    localparam logic [1:0] REG_KEY_LIMIT  = 2'd0;
    localparam logic [1:0] REG_VAL_LIMIT  = 2'd1;
    localparam logic [1:0] REG_ENTRIES    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  klen;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  vlen;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic walk_start;
        logic walk;
        logic upd_mode;
        logic decide;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic walk_done;
        logic need_upd;
        logic out_full;
    } t_stat;

    function automatic logic [KEY_W-1:0] f_byte_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        if (len >= LEN_W'(MAX_LEN)) begin
            m = '1;
        end else begin
            m = (KEY_W'(1) << {len, 3'b000}) - KEY_W'(1);
        end
        return m;
    endfunction

endpackage

// ===== rtl/lkvc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [63:0]        key_word;
    logic [3:0]         key_len;
    logic [63:0]        value_word;
    logic [3:0]         value_len;
    logic signed [31:0] lease;
    logic signed [31:0] now;

    modport source (output valid, op, key_word, key_len, value_word, value_len,
                    lease, now, input ready);
    modport sink   (input valid, op, key_word, key_len, value_word, value_len,
                    lease, now, output ready);
endinterface

interface lkvc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [3:0]  read_len;
    logic        evicted;

    modport source (output valid, status, read_value, read_len, evicted, input ready);
    modport sink   (input valid, status, read_value, read_len, evicted, output ready);
endinterface

// ===== rtl/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: check, scan, decide, rank update, response hand-off.
// ----------------------------------------------------------------------------
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.bad ? S_DECIDE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.walk_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = i_stat.need_upd ? S_UPDATE : S_DONE;
            end
            S_UPDATE: begin
                if (i_stat.walk_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.walk_start = 1'b1;
            end
            S_SCAN: begin
                o_cmd.walk = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.decide     = 1'b1;
                o_cmd.walk_start = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.walk     = 1'b1;
                o_cmd.upd_mode = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = !i_stat.out_full;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lkvc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_dp
// Entry and rank memories, scan compare, replacement choice, output register.
// ----------------------------------------------------------------------------
module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_op,
    input  logic [63:0]        i_key_word,
    input  logic [3:0]         i_key_len,
    input  logic [63:0]        i_value_word,
    input  logic [3:0]         i_value_len,
    input  logic signed [31:0] i_lease,
    input  logic signed [31:0] i_now,
    input  logic [3:0]         i_key_limit,
    input  logic [3:0]         i_value_limit,
    input  logic [6:0]         i_entries_in_use,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [63:0]        o_read_value,
    output logic [3:0]         o_read_len,
    output logic               o_evicted
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request registers
    logic                  r_op;
    logic [KEY_W-1:0]      r_key;
    logic [LEN_W-1:0]      r_klen;
    logic [VAL_W-1:0]      r_val;
    logic [LEN_W-1:0]      r_vlen;
    logic signed [31:0]    r_now;
    logic [TIME_W-1:0]     r_exp;
    logic                  r_bad;

    logic                  in_bad;
    logic signed [32:0]    exp_sum;
    logic [TIME_W-1:0]     exp_sat;

    // memories
    t_entry           mem_ent  [CAPACITY];
    logic [IDX_W-1:0] mem_rank [CAPACITY];
    t_entry           r_rd_ent;
    logic [IDX_W-1:0] r_rd_rank;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_alloc;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic [IDX_W-1:0] rd_addr;
    logic             walk_issue;

    logic             ent_we;
    t_entry           w_ent;
    logic             rank_we;
    logic [IDX_W-1:0] rank_wd;

    // decision registers
    logic             r_hit;
    logic [IDX_W-1:0] r_fidx;
    t_entry           r_fent;
    logic [IDX_W-1:0] r_frank;
    logic [IDX_W-1:0] r_lru;
    logic [IDX_W-1:0] r_tidx;
    logic [CNT_W-1:0] r_thr;

    logic [1:0]       r_res_status;
    logic [VAL_W-1:0] r_res_value;
    logic [LEN_W-1:0] r_res_len;
    logic             r_res_evict;

    // replacement decision
    logic [CNT_W-1:0] lim;
    logic             d_live;
    logic             d_upd;
    logic [IDX_W-1:0] n_tidx;
    logic [CNT_W-1:0] d_thr;
    logic             d_grow;
    logic [1:0]       d_status;
    logic             d_evict;

    always_comb begin
        in_bad = (i_key_len == '0) || (i_key_len >= i_key_limit)
              || (i_key_len > LEN_W'(MAX_LEN));
        if (i_op == OP_SET) begin
            if ((i_value_len >= i_value_limit) || (i_value_len > LEN_W'(MAX_LEN))
                || (i_lease <= 32'sd0)) begin
                in_bad = 1'b1;
            end
        end
        exp_sum = {i_now[31], i_now} + {i_lease[31], i_lease};
        exp_sat = (exp_sum > 33'sd2147483647) ? 32'h7FFF_FFFF : exp_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_key  <= i_key_word & f_byte_mask(i_key_len);
            r_klen <= i_key_len;
            r_val  <= i_value_word & f_byte_mask(i_value_len);
            r_vlen <= i_value_len;
            r_now  <= i_now;
            r_exp  <= exp_sat;
            r_bad  <= in_bad;
        end
    end

    assign rd_addr    = r_cnt[IDX_W-1:0];
    assign walk_issue = i_cmd.walk && (r_cnt < r_alloc);

    always_ff @(posedge i_clk) begin
        if (ent_we) mem_ent[n_tidx] <= w_ent;
        r_rd_ent <= mem_ent[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) mem_rank[r_pidx] <= rank_wd;
        r_rd_rank <= mem_rank[rd_addr];
    end

    // walk counter, shared by the key scan and the rank update pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_pv <= 1'b0;
        end else if (i_cmd.walk) begin
            r_pv <= walk_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_cnt <= '0;
        end else if (walk_issue) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.walk) r_pidx <= rd_addr;
    end

    // key scan: keep first match, find least recent entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start && !i_cmd.decide) begin
            r_hit <= 1'b0;
            r_lru <= '0;
        end else if (i_cmd.walk && !i_cmd.upd_mode && r_pv) begin
            if (!r_hit && r_rd_ent.klen == r_klen && r_rd_ent.key == r_key) begin
                r_hit   <= 1'b1;
                r_fidx  <= r_pidx;
                r_fent  <= r_rd_ent;
                r_frank <= r_rd_rank;
            end
            if (CNT_W'(r_rd_rank) == r_alloc - CNT_W'(1)) r_lru <= r_pidx;
        end
    end

    // rank update: target goes to zero, younger entries age by one
    always_comb begin
        rank_we = i_cmd.walk && i_cmd.upd_mode && r_pv;
        if (r_pidx == r_tidx) begin
            rank_wd = '0;
        end else if (CNT_W'(r_rd_rank) < r_thr) begin
            rank_wd = r_rd_rank + IDX_W'(1);
        end else begin
            rank_wd = r_rd_rank;
        end
    end

    always_comb begin
        if (i_entries_in_use == '0) begin
            lim = CNT_W'(1);
        end else if (32'(i_entries_in_use) > CAPACITY) begin
            lim = CNT_W'(CAPACITY);
        end else begin
            lim = CNT_W'(i_entries_in_use);
        end

        d_live   = r_hit && ($signed(r_fent.expiry) > r_now);
        d_upd    = 1'b0;
        n_tidx   = r_fidx;
        d_thr    = CNT_W'(r_frank);
        d_grow   = 1'b0;
        d_status = ST_BAD;
        d_evict  = 1'b0;

        if (!r_bad) begin
            if (r_op == OP_GET) begin
                d_status = d_live ? ST_HIT : ST_MISS;
                d_upd    = d_live;
            end else begin
                d_status = ST_HIT;
                d_upd    = 1'b1;
                if (!r_hit) begin
                    if (r_alloc < lim) begin
                        n_tidx = r_alloc[IDX_W-1:0];
                        d_thr  = r_alloc;
                        d_grow = 1'b1;
                    end else begin
                        n_tidx  = r_lru;
                        d_thr   = r_alloc - CNT_W'(1);
                        d_evict = 1'b1;
                    end
                end
            end
        end

        ent_we = i_cmd.decide && !r_bad && (r_op == OP_SET);
        w_ent  = '{key: r_key, klen: r_klen, value: r_val, vlen: r_vlen, expiry: r_exp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (i_cmd.decide && d_grow) begin
            r_alloc <= r_alloc + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_tidx       <= n_tidx;
            r_thr        <= d_thr;
            r_res_status <= d_status;
            r_res_evict  <= d_evict;
            r_res_value  <= (r_op == OP_GET && d_live) ? r_fent.value : '0;
            r_res_len    <= (r_op == OP_GET && d_live) ? r_fent.vlen : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status     <= r_res_status;
            o_read_value <= r_res_value;
            o_read_len   <= r_res_len;
            o_evicted    <= r_res_evict;
        end
    end

    always_comb begin
        o_stat.bad       = r_bad;
        o_stat.walk_done = (r_cnt >= r_alloc) && !r_pv;
        o_stat.need_upd  = d_upd;
        o_stat.out_full  = o_out_valid && !i_out_ready;
    end

endmodule

// ===== rtl/lru_key_value_cache_with_lease_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_with_lease_top
// Key-value cache with global LRU replacement and per-entry lease expiry.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake             Carries
//  i_req     in    valid/ready           op, key, value, lease, now
//  o_rsp     out   valid/ready           status, read value/len, evicted
//  APB       in    psel/penable/pready   key_limit, value_limit, entries_in_use
//
//  One item at a time. The key scan and the rank update each walk the entry and
//  rank memories once over the allocated entries; the rank update runs only
//  when an item changes the recency order, so a get miss skips it and a
//  rejected item skips both walks.
//  Reset needs no clearing pass; the allocation count starts at zero.
//  A stalled response waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module lru_key_value_cache_with_lease_top
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkvc_req_if.sink    i_req,
    lkvc_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] r_key_limit;
    logic [3:0] r_value_limit;
    logic [6:0] r_entries_in_use;
    logic       wr_en;

    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit      <= 4'd9;
            r_value_limit    <= 4'd9;
            r_entries_in_use <= 7'd64;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_KEY_LIMIT: r_key_limit      <= pwdata[3:0];
                REG_VAL_LIMIT: r_value_limit    <= pwdata[3:0];
                REG_ENTRIES:   r_entries_in_use <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_LIMIT: prdata = {28'd0, r_key_limit};
            REG_VAL_LIMIT: prdata = {28'd0, r_value_limit};
            REG_ENTRIES:   prdata = {25'd0, r_entries_in_use};
            default:       prdata = '0;
        endcase
    end

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lkvc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_req.op),
        .i_key_word       (i_req.key_word),
        .i_key_len        (i_req.key_len),
        .i_value_word     (i_req.value_word),
        .i_value_len      (i_req.value_len),
        .i_lease          (i_req.lease),
        .i_now            (i_req.now),
        .i_key_limit      (r_key_limit),
        .i_value_limit    (r_value_limit),
        .i_entries_in_use (r_entries_in_use),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_read_value     (o_rsp.read_value),
        .o_read_len       (o_rsp.read_len),
        .o_evicted        (o_rsp.evicted)
    );

endmodule

// ===== rtl/lkvc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the response channel.
// ----------------------------------------------------------------------------
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [63:0] i_read_value,
    input logic [3:0]  i_read_len,
    input logic        i_evicted
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_status) && $stable(i_read_value)
            && $stable(i_evicted))
        else $error("response payload changed while stalled");

    a_no_evict_unless_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_evicted |-> i_status == ST_HIT && i_read_len == 4'd0)
        else $error("eviction flagged on a non-store response");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_MISS || i_status == ST_BAD)
            |-> i_read_value == 64'd0 && i_read_len == 4'd0)
        else $error("miss or reject carries data");

endmodule

bind lru_key_value_cache_with_lease_top lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_read_value (o_rsp.read_value),
    .i_read_len   (o_rsp.read_len),
    .i_evicted    (o_rsp.evicted)
);
